// File: src/lvpr_pkg.sv
// ----------------------------------------------------------------------------
// lvpr_pkg: shared types and constants
// Byte codes and the result beat layout used by the bracket-run block.
// ----------------------------------------------------------------------------
package lvpr_pkg;

  // Byte that opens a bracket; every other byte closes one.
  localparam logic [7:0] OPEN_BYTE = 8'h28;

  // Fixed width of the reported length field.
  localparam int LONGEST_W = 13;

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 overflow;
  } lvpr_result_t;

endpackage

// File: src/longest_valid_paren_run.sv
// Each result beat is registered in lvpr_skid; the stack RAM is prefetched
// one entry ahead. Throughput: one beat per cycle while in_stall is low.
// The input stalls only when both the output register and skid stage are full.
// Reset (synchronous, rst_n low) clears the stack count, base, position, best
// length, overflow flag and output valids; the stack RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// longest_valid_paren_run: longest well-formed bracket run, one byte per beat
// Keeps a stack of unmatched opener positions in a RAM, with its two top
// entries cached in registers, and reports after each byte the longest
// well-formed run seen so far in the current string.
// ----------------------------------------------------------------------------
module longest_valid_paren_run
  import lvpr_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_character,
  input  logic                 in_first,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LONGEST_W-1:0] out_longest,
  output logic                 out_overflow
);

  // PW holds a position inside the string, CW a count up to MAX_LEN itself.
  localparam int PW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

  // Stack state. The RAM holds every pushed entry at its stack index; the
  // registers top_r and sec_r mirror entries count-1 and count-2 so that a
  // pop can measure its length without waiting on the RAM.
  logic [CW-1:0] sc_r, sc_nxt;
  logic [CW-1:0] base_r, base_nxt;    // last unmatched closer plus one
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic          ovf_r, ovf_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic [PW-1:0] sec_r, sec_nxt;

  logic          accept;
  logic          skid_stall;
  logic [CW-1:0] sc_e, base_e, pos_e, best_e;
  logic          ovf_e;
  logic [PW-1:0] cur;
  logic [CW-1:0] len;
  logic          we;
  logic [PW-1:0] waddr;
  logic [CW-1:0] rd_idx;
  logic [PW-1:0] rdata_r;
  lvpr_result_t  res;
  lvpr_result_t  out_res;
  logic [CW+LONGEST_W-1:0] best_ext;

  assign in_stall = skid_stall;
  assign accept   = in_valid & ~skid_stall;

  // The first flag clears the string state before this byte is handled.
  assign sc_e   = in_first ? '0 : sc_r;
  assign base_e = in_first ? '0 : base_r;
  assign pos_e  = in_first ? '0 : pos_r;
  assign best_e = in_first ? '0 : best_r;
  assign ovf_e  = in_first ? 1'b0 : ovf_r;
  assign cur    = pos_e[PW-1:0];

  always_comb begin
    sc_nxt   = sc_r;
    base_nxt = base_r;
    pos_nxt  = pos_r;
    best_nxt = best_r;
    ovf_nxt  = ovf_r;
    top_nxt  = top_r;
    sec_nxt  = sec_r;
    len      = '0;
    we       = 1'b0;
    waddr    = sc_e[PW-1:0];
    if (accept) begin
      sc_nxt   = sc_e;
      base_nxt = base_e;
      pos_nxt  = pos_e;
      best_nxt = best_e;
      ovf_nxt  = ovf_e;
      if (pos_e >= MAX_C) begin
        // Past the end of the longest allowed string: the byte only marks
        // overflow and the position stays put.
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_e + CW'(1);
        if (in_character == OPEN_BYTE) begin
          if (sc_e < MAX_C) begin
            we      = 1'b1;
            sc_nxt  = sc_e + CW'(1);
            top_nxt = cur;
            sec_nxt = top_r;
          end
        end else if (sc_e == '0) begin
          // Unmatched closer: the next run can start only after it.
          base_nxt = pos_e + CW'(1);
        end else begin
          sc_nxt  = sc_e - CW'(1);
          top_nxt = sec_r;
          // The RAM read issued last cycle delivered entry count-3, which
          // becomes the second entry after this pop.
          sec_nxt = rdata_r;
          if (sc_e == CW'(1)) begin
            len = pos_e + CW'(1) - base_e;
          end else begin
            len = pos_e - CW'(sec_r);
          end
          if (len > best_e) begin
            best_nxt = len;
          end
        end
      end
    end
  end

  // Prefetch the entry that a pop in the next cycle would need; a push in
  // this cycle writes at count, which never matches this address.
  assign rd_idx = sc_nxt - CW'(3);

  lvpr_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (PW)
  ) u_stack (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (cur),
    .raddr   (rd_idx[PW-1:0]),
    .rdata_r (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= '0;
      base_r <= '0;
      pos_r  <= '0;
      best_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      sc_r   <= sc_nxt;
      base_r <= base_nxt;
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      ovf_r  <= ovf_nxt;
    end
    top_r <= top_nxt;
    sec_r <= sec_nxt;
  end

  // The reported length keeps only its low LONGEST_W bits.
  assign best_ext     = {{LONGEST_W{1'b0}}, best_nxt};
  assign res.longest  = best_ext[LONGEST_W-1:0];
  assign res.overflow = ovf_nxt;

  lvpr_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_stall (skid_stall),
    .s_data  (res),
    .m_valid (out_valid),
    .m_stall (out_stall),
    .m_data  (out_res)
  );

  assign out_longest  = out_res.longest;
  assign out_overflow = out_res.overflow;

endmodule

// File: src/lvpr_ram.sv
// ----------------------------------------------------------------------------
// lvpr_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lvpr_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: src/lvpr_skid.sv
// ----------------------------------------------------------------------------
// lvpr_skid: output register with skid stage
// Holds result beats so the upstream stall is a plain register output.
// ----------------------------------------------------------------------------
module lvpr_skid
  import lvpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_stall,
  input  lvpr_result_t s_data,
  output logic         m_valid,
  input  logic         m_stall,
  output lvpr_result_t m_data
);

  logic         out_v_r, out_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  lvpr_result_t out_d_r, out_d_nxt;
  lvpr_result_t skid_d_r, skid_d_nxt;
  logic         s_acc;

  assign s_stall = skid_v_r;
  assign s_acc   = s_valid & ~skid_v_r;
  assign m_valid = out_v_r;
  assign m_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || !m_stall) begin
      // Output slot frees up: the older beat in the skid goes first.
      out_v_nxt  = skid_v_r | s_acc;
      out_d_nxt  = skid_v_r ? skid_d_r : s_data;
      skid_v_nxt = 1'b0;
    end else if (s_acc) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = s_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule
